### hdl/tbld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbld_pkg
// Types, codes and constants shared by the two-button long-press detector.
// ----------------------------------------------------------------------------
package tbld_pkg;

  localparam int unsigned ThreshW       = 8;
  localparam int unsigned TickMs        = 20;
  localparam int unsigned HoldMs        = 500;
  localparam logic [ThreshW-1:0] ThreshRst = ThreshW'(HoldMs / TickMs);

  // Servo command codes
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_CENTER = 2'd1;
  localparam logic [1:0] CMD_CCW    = 2'd2;
  localparam logic [1:0] CMD_CW     = 2'd3;

  // Reported state codes
  localparam logic [2:0] CODE_IDLE   = 3'd0;
  localparam logic [2:0] CODE_ONE    = 3'd1;
  localparam logic [2:0] CODE_TWO    = 3'd2;
  localparam logic [2:0] CODE_BOTH   = 3'd3;
  localparam logic [2:0] CODE_CENTER = 3'd4;
  localparam logic [2:0] CODE_CCW    = 3'd5;
  localparam logic [2:0] CODE_CW     = 3'd6;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ONE    = 7'b0000010,
    ST_TWO    = 7'b0000100,
    ST_BOTH   = 7'b0001000,
    ST_CENTER = 7'b0010000,
    ST_CCW    = 7'b0100000,
    ST_CW     = 7'b1000000
  } press_state_t;

  typedef struct packed {
    logic button_one;
    logic button_two;
    logic period_tick;
  } in_item_t;

  typedef struct packed {
    logic [1:0] servo_command;
    logic [2:0] machine_state;
  } out_item_t;

  // Handshake between the input register and the result stage
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage
`default_nettype wire

### hdl/tbld_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbld_in_reg
// Input register: captures one poll item and holds it until the result stage
// takes it.
// ----------------------------------------------------------------------------
module tbld_in_reg
  import tbld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  input  wire logic       take,
  output stage_ctl_t      ctl,
  output in_item_t        item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // hold while an item sits here and the result side cannot take it
  assign in_stall  = valid_r & ~take;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  assign ctl.valid = valid_r;
  assign ctl.take  = take;
  assign item      = item_r;

endmodule
`default_nettype wire

### hdl/tbld_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbld_core
// Press state machine and hold counter; forms one result per poll item.
// ----------------------------------------------------------------------------
module tbld_core
  import tbld_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire stage_ctl_t         ctl,
  input  wire in_item_t           item,
  input  wire logic [ThreshW-1:0] threshold,
  output out_item_t               result
);

  press_state_t       state_r;
  press_state_t       state_nxt;
  logic [ThreshW-1:0] count_r;
  logic [ThreshW-1:0] count_nxt;
  logic               fire;
  logic               ripe;
  logic               b1;
  logic               b2;

  assign fire = ctl.valid & ctl.take;
  assign ripe = count_r >= threshold;
  assign b1   = item.button_one;
  assign b2   = item.button_two;

  // transition uses the count from before this poll
  always_comb begin
    case (state_r)
      ST_IDLE: begin
        if (b1 && b2)  state_nxt = ST_BOTH;
        else if (b1)   state_nxt = ST_ONE;
        else if (b2)   state_nxt = ST_TWO;
        else           state_nxt = ST_IDLE;
      end
      ST_BOTH: begin
        if (!b1 || !b2) state_nxt = ST_IDLE;
        else            state_nxt = ripe ? ST_CENTER : ST_BOTH;
      end
      ST_ONE: begin
        if (!b1)      state_nxt = ST_IDLE;
        else if (b2)  state_nxt = ST_BOTH;
        else          state_nxt = ripe ? ST_CCW : ST_ONE;
      end
      ST_TWO: begin
        if (!b2)      state_nxt = ST_IDLE;
        else if (b1)  state_nxt = ST_BOTH;
        else          state_nxt = ripe ? ST_CW : ST_TWO;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // act on the new state
  always_comb begin
    count_nxt             = count_r;
    result.servo_command  = CMD_NONE;
    result.machine_state  = CODE_IDLE;
    case (state_nxt)
      ST_IDLE: begin
        count_nxt = '0;
      end
      ST_ONE, ST_TWO, ST_BOTH: begin
        if (item.period_tick && (count_r < threshold)) begin
          count_nxt = count_r + ThreshW'(1);
        end
        if (state_nxt == ST_ONE)       result.machine_state = CODE_ONE;
        else if (state_nxt == ST_TWO)  result.machine_state = CODE_TWO;
        else                           result.machine_state = CODE_BOTH;
      end
      ST_CENTER: begin
        result.servo_command = CMD_CENTER;
        result.machine_state = CODE_CENTER;
      end
      ST_CCW: begin
        result.servo_command = CMD_CCW;
        result.machine_state = CODE_CCW;
      end
      ST_CW: begin
        result.servo_command = CMD_CW;
        result.machine_state = CODE_CW;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/two_button_long_press_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_button_long_press_detector
// Polls two button levels with a period tick and issues a servo command once
// a single or double press has been held for hold_threshold ticks.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake        Payload
// in_      in   valid / stall    in_item_t  (button_one, button_two, tick)
// out_     out  valid / stall    out_item_t (servo_command, machine_state)
// cfg_     in   valid / ready    cfg_data   (hold_threshold, 8 bits)
//
// One item per cycle sustained while out_stall stays low.
// Per item: input register, one pass of state logic, result register.
// Reset (rst_n low, synchronous) empties both registers, sets idle, zero count
// and a threshold of 25. cfg_ready is always high.
// A stalled result holds; the input register then fills and raises in_stall.
// ----------------------------------------------------------------------------
module two_button_long_press_detector
  import tbld_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [ThreshW-1:0] cfg_data
);

  logic               take;
  stage_ctl_t         ctl;
  in_item_t           item;
  out_item_t          result;
  logic [ThreshW-1:0] thresh_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_item_t          out_item_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= ThreshRst;
    end else if (cfg_valid && cfg_ready) begin
      thresh_r <= cfg_data;
    end
  end

  // the result register can load when empty or being drained
  assign take = ~out_valid_r | ~out_stall;

  tbld_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .ctl      (ctl),
    .item     (item)
  );

  tbld_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .item      (item),
    .threshold (thresh_r),
    .result    (result)
  );

  assign out_valid_nxt = take ? ctl.valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid && take) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire
